/* rtl/core/pidc_pkg.sv */
// Shared types, register indexes and constants of the PID controller.
`default_nettype none

package pidc_pkg;

	// Field widths.
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned GAIN_W   = 16;
	localparam int unsigned LIMIT_W  = 15;
	localparam int unsigned ERR_W    = 17;
	localparam int unsigned INTEG_W  = 24;
	localparam int unsigned FRAC_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Angle wrap thresholds in degrees.
	localparam logic signed [ERR_W-1:0] ANGLE_HALF     = ERR_W'(180);
	localparam logic signed [ERR_W-1:0] ANGLE_HALF_NEG = -ERR_W'(180);
	localparam logic signed [ERR_W-1:0] ANGLE_FULL     = ERR_W'(360);

	// Register reset values.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		IDX_GAIN_PROP    = 3'd0,
		IDX_GAIN_INTEG   = 3'd1,
		IDX_GAIN_DERIV   = 3'd2,
		IDX_MAX_OUTPUT   = 3'd3,
		IDX_MAX_INTEGRAL = 3'd4,
		IDX_ANGLE_MODE   = 3'd5
	} cfg_idx_t;

	// Current register contents as seen by the datapath.
	typedef struct packed {
		logic [GAIN_W-1:0]  gain_prop;
		logic [GAIN_W-1:0]  gain_integ;
		logic [GAIN_W-1:0]  gain_deriv;
		logic [LIMIT_W-1:0] max_output;
		logic [LIMIT_W-1:0] max_integral;
		logic               angle_mode;
	} pidc_cfg_t;

endpackage

`default_nettype wire

/* rtl/core/pidc_cfg_regs.sv */
// Configuration register file of the PID controller.
`default_nettype none

module pidc_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data,
	output pidc_pkg::pidc_cfg_t                  cfg
);
	import pidc_pkg::*;

	pidc_cfg_t cfg_q;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop    <= '0;
			cfg_q.gain_integ   <= '0;
			cfg_q.gain_deriv   <= '0;
			cfg_q.max_output   <= LIMIT_RESET;
			cfg_q.max_integral <= LIMIT_RESET;
			cfg_q.angle_mode   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				IDX_GAIN_PROP:    cfg_q.gain_prop    <= cfg_data[GAIN_W-1:0];
				IDX_GAIN_INTEG:   cfg_q.gain_integ   <= cfg_data[GAIN_W-1:0];
				IDX_GAIN_DERIV:   cfg_q.gain_deriv   <= cfg_data[GAIN_W-1:0];
				IDX_MAX_OUTPUT:   cfg_q.max_output   <= cfg_data[LIMIT_W-1:0];
				IDX_MAX_INTEGRAL: cfg_q.max_integral <= cfg_data[LIMIT_W-1:0];
				IDX_ANGLE_MODE:   cfg_q.angle_mode   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A mode write lands in the register.
	a_angle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == IDX_ANGLE_MODE) |=> (cfg_q.angle_mode == $past(cfg_data[0])))
		else $error("angle mode write lost");

	// A limit write lands in the register.
	a_limit_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == IDX_MAX_OUTPUT)
		|=> (cfg_q.max_output == $past(cfg_data[LIMIT_W-1:0])))
		else $error("output limit write lost");

endmodule

`default_nettype wire

/* rtl/core/pidc_core.sv */
// PID arithmetic: error, wrap, three products, clamped integrator and output clamp.
`default_nettype none

module pidc_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire pidc_pkg::pidc_cfg_t                cfg,
	input  wire logic                               step,
	input  wire logic signed [pidc_pkg::DATA_W-1:0] measured,
	input  wire logic signed [pidc_pkg::DATA_W-1:0] target,
	output logic signed [pidc_pkg::DATA_W-1:0]      drive
);
	import pidc_pkg::*;

	localparam int unsigned PROD_W  = ERR_W + GAIN_W + 1;
	localparam int unsigned DIFF_W  = ERR_W + 1;
	localparam int unsigned DPROD_W = DIFF_W + GAIN_W + 1;
	localparam int unsigned ASUM_W  = PROD_W + 1;
	localparam int unsigned SUM_W   = DPROD_W + 2;
	localparam int unsigned WHOLE_W = SUM_W - FRAC_W;

	logic signed [ERR_W-1:0]   err_raw;
	logic signed [ERR_W-1:0]   err;
	logic signed [GAIN_W:0]    gp_s;
	logic signed [GAIN_W:0]    gi_s;
	logic signed [GAIN_W:0]    gd_s;
	logic signed [PROD_W-1:0]  p_term;
	logic signed [PROD_W-1:0]  i_prod;
	logic signed [DIFF_W-1:0]  err_diff;
	logic signed [DPROD_W-1:0] d_term;
	logic signed [ASUM_W-1:0]  acc_sum;
	logic signed [ASUM_W-1:0]  ilim;
	logic signed [INTEG_W-1:0] acc_new;
	logic signed [SUM_W-1:0]   sum;
	logic signed [WHOLE_W-1:0] whole;
	logic signed [WHOLE_W-1:0] olim;
	logic signed [WHOLE_W-1:0] whole_sat;

	logic signed [ERR_W-1:0]   prior_err_q;
	logic signed [INTEG_W-1:0] integ_q;

	// Error with a single optional 360 degree correction.
	always_comb begin
		err_raw = ERR_W'(target) - ERR_W'(measured);
		err = err_raw;
		if (cfg.angle_mode) begin
			if (err_raw > ANGLE_HALF) begin
				err = err_raw - ANGLE_FULL;
			end else if (err_raw < ANGLE_HALF_NEG) begin
				err = err_raw + ANGLE_FULL;
			end
		end
	end

	// Gain products, each with eight fraction bits.
	always_comb begin
		gp_s = $signed({1'b0, cfg.gain_prop});
		gi_s = $signed({1'b0, cfg.gain_integ});
		gd_s = $signed({1'b0, cfg.gain_deriv});
		err_diff = DIFF_W'(err) - DIFF_W'(prior_err_q);
		p_term = PROD_W'(gp_s) * PROD_W'(err);
		i_prod = PROD_W'(gi_s) * PROD_W'(err);
		d_term = DPROD_W'(gd_s) * DPROD_W'(err_diff);
	end

	// Integrator update, saturated to the integral limit.
	always_comb begin
		ilim = $signed(ASUM_W'({1'b0, cfg.max_integral, {FRAC_W{1'b0}}}));
		acc_sum = ASUM_W'(integ_q) + ASUM_W'(i_prod);
		if (acc_sum > ilim) begin
			acc_new = INTEG_W'(ilim);
		end else if (acc_sum < -ilim) begin
			acc_new = INTEG_W'(-ilim);
		end else begin
			acc_new = INTEG_W'(acc_sum);
		end
	end

	// Sum, truncation toward zero and output saturation.
	always_comb begin
		sum = SUM_W'(p_term) + SUM_W'(d_term) + SUM_W'(acc_new);
		whole = WHOLE_W'(sum >>> FRAC_W);
		if (sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0)) begin
			whole = whole + WHOLE_W'(1);
		end
		olim = $signed(WHOLE_W'({1'b0, cfg.max_output}));
		if (whole > olim) begin
			whole_sat = olim;
		end else if (whole < -olim) begin
			whole_sat = -olim;
		end else begin
			whole_sat = whole;
		end
		drive = DATA_W'(whole_sat);
	end

	// Controller state advances once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_err_q <= '0;
			integ_q     <= '0;
		end else if (step) begin
			prior_err_q <= err;
			integ_q     <= acc_new;
		end
	end

	// After an update the integrator sits inside its limit.
	a_integ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> ((integ_q <= $signed({1'b0, cfg.max_integral, {FRAC_W{1'b0}}}))
		&& (integ_q >= -$signed({1'b0, cfg.max_integral, {FRAC_W{1'b0}}}))))
		else $error("integrator beyond its limit");

	// The stored error is what the item produced.
	a_prior_err: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (prior_err_q == $past(err)))
		else $error("prior error not updated");

endmodule

`default_nettype wire

/* rtl/core/pid_controller_with_clamps.sv */
// Top level of the positional PID controller with clamped integrator and output.
// One item is taken per clock cycle when the result side keeps up; an accepted item is held
// in the input register and then moves into the result register, from which its result is
// presented. The integrator loop keeps the datapath unsplit: the clamped integrator
// of one item feeds the next, so error, three products (17 x 17 bits for the proportional
// and integral terms, 17 x 18 bits for the derivative term), the integrator add and clamp,
// and the output clamp all sit between the input register and the result register.
// A held result lets the input register take one more item and then stalls the input;
// s_tready follows m_tready in the same cycle, so a full pipeline keeps streaming while
// results are taken. Configuration writes are always accepted and take effect next cycle.
`default_nettype none

module pid_controller_with_clamps (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [31:0]                     s_tdata,  // measured[15:0], target[31:16]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [15:0]                          m_tdata,  // drive[15:0]
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pidc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pidc_pkg::*;

	pidc_cfg_t cfg;

	logic                     in_valid_s1;
	logic signed [DATA_W-1:0] measured_s1;
	logic signed [DATA_W-1:0] target_s1;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] drive_q;
	logic signed [DATA_W-1:0] drive_next;
	logic                     out_free;
	logic                     step;

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.measured (measured_s1),
		.target   (target_s1),
		.drive    (drive_next)
	);

	// Flow control: the input register moves on whenever the result slot frees up.
	assign out_free = !out_valid_q || m_tready;
	assign step     = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = drive_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				in_valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				out_valid_q <= in_valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			measured_s1 <= $signed(s_tdata[DATA_W-1:0]);
			target_s1   <= $signed(s_tdata[2*DATA_W-1:DATA_W]);
		end
		if (step) begin
			drive_q <= drive_next;
		end
	end

	// A presented result is within the output limit.
	a_drive_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((drive_q <= $signed({1'b0, cfg.max_output}))
		&& (drive_q >= -$signed({1'b0, cfg.max_output}))))
		else $error("drive beyond output limit");

	// A waiting item moves into a free result slot.
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("item stuck in input register");

endmodule

`default_nettype wire
